>>> rtl/pbs_pkg.sv
// shared constants, codes and types for the packet block sequencer
package pbs_pkg;

	// fixed geometry: the ring and row fields have fixed widths, so these are not parameters
	localparam int unsigned FINE_CHANNELS = 4096;
	localparam int unsigned FC_BITS = 12;
	localparam int unsigned BEAMS = 8;
	localparam int unsigned RING_BLOCKS = 4;
	localparam int unsigned RB_BITS = 2;

	localparam int unsigned SEQ_W = 48;
	localparam int unsigned CHAN_W = 12;
	localparam int unsigned BEAM_W = 4;
	localparam int unsigned CNT_W = 16;
	localparam int unsigned RUN_W = 8;
	localparam int unsigned ROW_W = 15;
	localparam int unsigned OUTCOME_W = 2;
	localparam int unsigned MISS_W = 17;
	localparam int unsigned MBEAM_W = 4;

	localparam logic [OUTCOME_W-1:0] OUTCOME_ACCEPTED = 2'd0;
	localparam logic [OUTCOME_W-1:0] OUTCOME_LATE = 2'd1;
	localparam logic [OUTCOME_W-1:0] OUTCOME_OUT_OF_SEQ = 2'd2;
	localparam logic [OUTCOME_W-1:0] OUTCOME_BAD_BEAM = 2'd3;

	typedef struct packed {
		logic [SEQ_W-1:0] seq_count;
		logic [CHAN_W-1:0] first_chan;
		logic [BEAM_W-1:0] beam_id;
		logic [CHAN_W-1:0] chan_count;
	} pbs_hdr_t;

	typedef struct packed {
		logic [SEQ_W-1:0] start;
		logic [RUN_W-1:0] run;
		logic [RING_BLOCKS-1:0][CNT_W-1:0] counts;
		logic [CHAN_W-1:0] lat_first;
		logic [CHAN_W-1:0] lat_count;
	} pbs_state_t;

	typedef struct packed {
		logic [OUTCOME_W-1:0] outcome;
		logic [RB_BITS-1:0] dest_block;
		logic [ROW_W-1:0] dest_row;
		logic chan_mismatch;
		logic block_filled;
		logic [RB_BITS-1:0] filled_block;
		logic [SEQ_W-1:0] filled_start;
		logic [MBEAM_W-1:0] missed_beams;
		logic [CHAN_W-1:0] missed_packets;
		logic resynced;
		logic [SEQ_W-1:0] current_start;
	} pbs_res_t;

endpackage

>>> rtl/pbs_decide.sv
// classifies one registered header against the sequencer state and forms next state and result
module pbs_decide (
	input  pbs_pkg::pbs_hdr_t   hdr,
	input  pbs_pkg::pbs_state_t st,
	output pbs_pkg::pbs_state_t nxt,
	output pbs_pkg::pbs_res_t   res
);

	localparam logic [pbs_pkg::SEQ_W-1:0] FC_SEQ = pbs_pkg::SEQ_W'(pbs_pkg::FINE_CHANNELS);
	localparam logic [pbs_pkg::SEQ_W-1:0] WIN_END = pbs_pkg::SEQ_W'(2 * pbs_pkg::FINE_CHANNELS);
	localparam logic [pbs_pkg::SEQ_W-1:0] CLOSE_AT =
		pbs_pkg::SEQ_W'(3 * (pbs_pkg::FINE_CHANNELS / 2));
	localparam logic [pbs_pkg::SEQ_W-1:0] LATE_END =
		pbs_pkg::SEQ_W'(2 * pbs_pkg::FINE_CHANNELS * pbs_pkg::RING_BLOCKS);
	localparam logic [pbs_pkg::MISS_W-1:0] TOTAL =
		pbs_pkg::MISS_W'(pbs_pkg::BEAMS * pbs_pkg::FINE_CHANNELS);
	localparam logic [pbs_pkg::RUN_W-1:0] RUN_LIMIT = pbs_pkg::RUN_W'(2 * pbs_pkg::BEAMS);
	localparam logic [pbs_pkg::BEAM_W-1:0] BEAM_LIMIT = pbs_pkg::BEAM_W'(pbs_pkg::BEAMS);

	logic [pbs_pkg::SEQ_W-1:0] ahead;
	logic [pbs_pkg::SEQ_W-1:0] back;
	logic [pbs_pkg::RB_BITS-1:0] cb;
	logic [pbs_pkg::RB_BITS-1:0] pb;
	logic [pbs_pkg::RB_BITS-1:0] clr_idx;
	logic in_window;
	logic closing;
	logic late;
	logic [pbs_pkg::MISS_W-1:0] got;
	logic [pbs_pkg::MISS_W-1:0] miss;
	logic [pbs_pkg::RB_BITS-1:0] diff;
	logic [pbs_pkg::SEQ_W-1:0] resync_p;
	logic [pbs_pkg::RB_BITS-1:0] rs_cb;
	logic [pbs_pkg::RB_BITS-1:0] rs_nx;
	logic [pbs_pkg::RUN_W-1:0] run_inc;

	assign ahead = hdr.seq_count - st.start;
	assign back = st.start - hdr.seq_count;
	assign cb = st.start[pbs_pkg::FC_BITS +: pbs_pkg::RB_BITS];
	assign pb = hdr.seq_count[pbs_pkg::FC_BITS +: pbs_pkg::RB_BITS];
	// block after the new current block once this one closes
	assign clr_idx = cb + pbs_pkg::RB_BITS'(2);

	assign in_window = !ahead[pbs_pkg::SEQ_W-1] && (ahead < WIN_END);
	assign closing = in_window && (ahead >= CLOSE_AT);
	assign late = ahead[pbs_pkg::SEQ_W-1] && (back < LATE_END);

	assign got = pbs_pkg::MISS_W'(st.counts[cb]);
	assign miss = (got > TOTAL) ? '0 : (TOTAL - got);

	// move the packet forward onto the ring slot of the current block
	assign diff = cb - pb;
	assign resync_p = hdr.seq_count + {{(pbs_pkg::SEQ_W - pbs_pkg::FC_BITS - pbs_pkg::RB_BITS){1'b0}},
		diff, {pbs_pkg::FC_BITS{1'b0}}};
	assign rs_cb = resync_p[pbs_pkg::FC_BITS +: pbs_pkg::RB_BITS];
	assign rs_nx = rs_cb + pbs_pkg::RB_BITS'(1);

	assign run_inc = (st.run != '1) ? (st.run + pbs_pkg::RUN_W'(1)) : st.run;

	always_comb begin
		nxt = st;
		res = '0;
		if (in_window) begin
			if (closing) begin
				res.block_filled = 1'b1;
				res.filled_block = cb;
				res.filled_start = st.start;
				res.missed_beams = miss[pbs_pkg::FC_BITS +: pbs_pkg::MBEAM_W];
				res.missed_packets = miss[pbs_pkg::FC_BITS-1:0];
				nxt.start = st.start + FC_SEQ;
				nxt.lat_first = '0;
				nxt.lat_count = '0;
				nxt.counts[clr_idx] = '0;
			end
			nxt.run = '0;
			if (nxt.counts[pb] != '1) begin
				nxt.counts[pb] = nxt.counts[pb] + pbs_pkg::CNT_W'(1);
			end
			if (hdr.beam_id >= BEAM_LIMIT) begin
				res.outcome = pbs_pkg::OUTCOME_BAD_BEAM;
			end else begin
				// zero channel count means nothing latched for this period yet
				if (nxt.lat_count == '0) begin
					nxt.lat_count = hdr.chan_count;
					nxt.lat_first = hdr.first_chan;
				end
				res.outcome = pbs_pkg::OUTCOME_ACCEPTED;
				res.dest_block = pb;
				res.dest_row = {hdr.beam_id[pbs_pkg::ROW_W-pbs_pkg::FC_BITS-1:0],
					hdr.seq_count[pbs_pkg::FC_BITS-1:0]};
				res.chan_mismatch = (hdr.first_chan != nxt.lat_first) ||
					(hdr.chan_count != nxt.lat_count);
			end
		end else if (late) begin
			res.outcome = pbs_pkg::OUTCOME_LATE;
		end else begin
			res.outcome = pbs_pkg::OUTCOME_OUT_OF_SEQ;
			nxt.run = run_inc;
			if (run_inc > RUN_LIMIT) begin
				nxt.start = {resync_p[pbs_pkg::SEQ_W-1:pbs_pkg::FC_BITS], {pbs_pkg::FC_BITS{1'b0}}};
				nxt.lat_first = '0;
				nxt.lat_count = '0;
				nxt.counts[rs_cb] = '0;
				nxt.counts[rs_nx] = '0;
				res.resynced = 1'b1;
			end
		end
		res.current_start = nxt.start;
	end

endmodule

>>> rtl/packet_block_sequencer.sv
// top level of the packet block sequencer: header register, decision logic, result register
//
//  channel  | valid     | stall     | payload
//  ---------+-----------+-----------+-----------------------------------------------
//  header   | hdr_valid | hdr_stall | seq_count first_chan beam_id chan_count
//  result   | res_valid | res_stall | outcome dest_block dest_row chan_mismatch ...
//
// one request per cycle sustained while no result is stalled; a header taken into the header register
// is offered as a result from the result register
// the decision is combinational between the header register and the result register,
// and the sequencer state register loads in the same cycle as the result register
// arst_n clears the start count, run counter, block counters and channel latches
// a stalled result holds the result register and, with it, the header register
module packet_block_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        hdr_valid,
	output logic        hdr_stall,
	input  logic [47:0] seq_count,
	input  logic [11:0] first_chan,
	input  logic [3:0]  beam_id,
	input  logic [11:0] chan_count,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [1:0]  outcome,
	output logic [1:0]  dest_block,
	output logic [14:0] dest_row,
	output logic        chan_mismatch,
	output logic        block_filled,
	output logic [1:0]  filled_block,
	output logic [47:0] filled_start,
	output logic [3:0]  missed_beams,
	output logic [11:0] missed_packets,
	output logic        resynced,
	output logic [47:0] current_start
);

	pbs_pkg::pbs_hdr_t hdr_s1;
	logic valid_s1;
	pbs_pkg::pbs_state_t state_q;
	pbs_pkg::pbs_state_t state_nxt;
	pbs_pkg::pbs_res_t res_comb;
	pbs_pkg::pbs_res_t res_s2;
	logic valid_s2;
	logic advance;

	// result slot frees when empty or being taken
	assign advance = !valid_s2 || !res_stall;
	assign hdr_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!hdr_stall) begin
			valid_s1 <= hdr_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!hdr_stall && hdr_valid) begin
			hdr_s1 <= '{seq_count: seq_count, first_chan: first_chan,
				beam_id: beam_id, chan_count: chan_count};
		end
	end

	pbs_decide u_decide (
		.hdr (hdr_s1),
		.st  (state_q),
		.nxt (state_nxt),
		.res (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			state_q <= '0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign res_valid = valid_s2;
	assign outcome = res_s2.outcome;
	assign dest_block = res_s2.dest_block;
	assign dest_row = res_s2.dest_row;
	assign chan_mismatch = res_s2.chan_mismatch;
	assign block_filled = res_s2.block_filled;
	assign filled_block = res_s2.filled_block;
	assign filled_start = res_s2.filled_start;
	assign missed_beams = res_s2.missed_beams;
	assign missed_packets = res_s2.missed_packets;
	assign resynced = res_s2.resynced;
	assign current_start = res_s2.current_start;

endmodule
